FILE: rtl/core/lese_pkg.sv
// ----------------------------------------------------------------------------
// lese_pkg
// Shared types and constants for the lattice edge swap engine.
// ----------------------------------------------------------------------------
package lese_pkg;

    localparam int NODE_BITS   = 6;
    localparam int EDGE_BITS   = 10;
    localparam int WEIGHT_BITS = 16;
    localparam int CELL_BITS   = 2 * NODE_BITS;
    localparam int NODES       = 1 << NODE_BITS;
    localparam int EDGES       = 1 << EDGE_BITS;
    localparam int CELLS       = 1 << CELL_BITS;
    localparam int EWORD_BITS  = 2 * NODE_BITS;
    localparam int NCNT_BITS   = 7;
    localparam int SUM_BITS    = NCNT_BITS + 1;

    localparam logic [NCNT_BITS-1:0] NCNT_RESET = 7'd64;
    localparam logic [NCNT_BITS-1:0] NCNT_MIN   = 7'd2;
    localparam logic [NCNT_BITS-1:0] NCNT_MAX   = 7'd64;

    localparam logic [2:0] CMD_WR_WEIGHT = 3'd0;
    localparam logic [2:0] CMD_RD_WEIGHT = 3'd1;
    localparam logic [2:0] CMD_WR_EDGE   = 3'd2;
    localparam logic [2:0] CMD_RD_EDGE   = 3'd3;
    localparam logic [2:0] CMD_SWAP      = 3'd4;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_SHARED    = 3'd1;
    localparam logic [2:0] STAT_LINK      = 3'd2;
    localparam logic [2:0] STAT_DIST      = 3'd3;
    localparam logic [2:0] STAT_SAME_EDGE = 3'd4;

    typedef enum logic [2:0] {
        WA_IN, WA_AD, WA_CB, WA_SRC, WA_DST, WA_CLR
    } waddr_sel_t;

    typedef enum logic [1:0] {
        WD_IN, WD_RD, WD_ZERO
    } wdata_sel_t;

    typedef enum logic {
        EA_E1, EA_E2
    } eaddr_sel_t;

    typedef enum logic [1:0] {
        ED_IN, ED_CD, ED_AD, ED_CB
    } edata_sel_t;

    typedef struct packed {
        logic       cap_in;
        logic       clr_step;
        logic       w_we;
        waddr_sel_t w_asel;
        wdata_sel_t w_dsel;
        logic       e_we;
        eaddr_sel_t e_asel;
        edata_sel_t e_dsel;
        logic       lat_ab;
        logic       lat_cd;
        logic       link_first;
        logic       link_next;
        logic       dist_cap;
        logic       set_status;
        logic [2:0] status;
        logic       cap_rw;
        logic       cap_edge;
        logic       load_out;
        logic [1:0] move;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic       same_edge;
        logic       shared;
        logic       link;
        logic       dist_fail;
        logic       clr_done;
    } dp_stat_t;

endpackage

FILE: rtl/core/lattice_edge_swap_engine_core.sv
// ----------------------------------------------------------------------------
// lattice_edge_swap_engine_core
// Weight matrix and edge list store with lattice-biased edge swap step.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake            | Content
// s_       | in  | s_tvalid / s_tready  | command in tuser, operands in tdata
// m_       | out | m_tvalid / m_tready  | status in tuser, read data in tdata
// cfg_     | in  | cfg_valid/cfg_ready  | node_count (ring size)
//
// A full swap makes four weight moves over one single-port RAM,
//   each a read, a write and a zeroing of the source.
// Reset: all 4096 weight entries are swept to zero, one entry per cycle;
//   no transaction is accepted during the sweep, cfg writes are taken.
// One transaction in flight; the next is accepted while a result waits on m_.
// A stalled m_ side holds the finished result and the sequencer in its final step.
// ----------------------------------------------------------------------------
module lattice_edge_swap_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    // tuser: command[2:0]
    input  logic [2:0]  s_tuser,
    // tdata: row_node[5:0], col_node[11:6], weight_value[27:12],
    //        first_edge[37:28], second_edge[47:38], flip_second[48], zero pad
    input  logic [55:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tuser: status[2:0]
    output logic [2:0]  m_tuser,
    // tdata: read_weight[15:0], read_first_node[21:16],
    //        read_second_node[27:22], zero pad
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic [6:0]  cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    lese_pkg::ctrl_cmd_t cmd;
    lese_pkg::dp_stat_t  stat;

    logic [lese_pkg::WEIGHT_BITS-1:0] out_weight;
    logic [lese_pkg::NODE_BITS-1:0]   out_first, out_second;

    // register always writable
    assign cfg_ready = 1'b1;

    lese_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lese_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .in_command (s_tuser),
        .in_row     (s_tdata[5:0]),
        .in_col     (s_tdata[11:6]),
        .in_weight  (s_tdata[27:12]),
        .in_e1      (s_tdata[37:28]),
        .in_e2      (s_tdata[47:38]),
        .in_flip    (s_tdata[48]),
        .cmd        (cmd),
        .stat       (stat),
        .out_status (m_tuser),
        .out_weight (out_weight),
        .out_first  (out_first),
        .out_second (out_second)
    );

    assign m_tdata = {4'd0, out_second, out_first, out_weight};

endmodule

FILE: rtl/core/lese_ram.sv
// ----------------------------------------------------------------------------
// lese_ram
// Generic single-port RAM, synchronous write, registered read.
// ----------------------------------------------------------------------------
module lese_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/lese_dp.sv
// ----------------------------------------------------------------------------
// lese_dp
// Datapath: weight and edge stores, operand registers, distance test, results.
// ----------------------------------------------------------------------------
module lese_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [lese_pkg::NCNT_BITS-1:0]       cfg_data,
    input  logic [2:0]                           in_command,
    input  logic [lese_pkg::NODE_BITS-1:0]       in_row,
    input  logic [lese_pkg::NODE_BITS-1:0]       in_col,
    input  logic [lese_pkg::WEIGHT_BITS-1:0]     in_weight,
    input  logic [lese_pkg::EDGE_BITS-1:0]       in_e1,
    input  logic [lese_pkg::EDGE_BITS-1:0]       in_e2,
    input  logic                                 in_flip,
    input  lese_pkg::ctrl_cmd_t                  cmd,
    output lese_pkg::dp_stat_t                   stat,
    output logic [2:0]                           out_status,
    output logic [lese_pkg::WEIGHT_BITS-1:0]     out_weight,
    output logic [lese_pkg::NODE_BITS-1:0]       out_first,
    output logic [lese_pkg::NODE_BITS-1:0]       out_second
);

    localparam int NB = lese_pkg::NODE_BITS;
    localparam int WB = lese_pkg::WEIGHT_BITS;
    localparam int CB = lese_pkg::NCNT_BITS;
    localparam int SB = lese_pkg::SUM_BITS;

    logic [2:0]    command_reg;
    logic [NB-1:0] row_reg, col_reg;
    logic [WB-1:0] weight_reg;
    logic [lese_pkg::EDGE_BITS-1:0] e1_reg, e2_reg;
    logic          flip_reg;
    logic [NB-1:0] a_reg, b_reg, c_reg, d_reg;
    logic          link_reg;
    logic [SB-1:0] sum_keep_reg, sum_new_reg;
    logic [CB-1:0] ncnt_reg;
    logic [lese_pkg::CELL_BITS-1:0] clr_reg;
    logic [2:0]    res_status_reg;
    logic [WB-1:0] res_weight_reg;
    logic [NB-1:0] res_first_reg, res_second_reg;
    logic [2:0]    out_status_reg;
    logic [WB-1:0] out_weight_reg;
    logic [NB-1:0] out_first_reg, out_second_reg;

    logic [lese_pkg::CELL_BITS-1:0]  w_addr, src_addr, dst_addr;
    logic [WB-1:0]                   w_wdata, w_rdata;
    logic [lese_pkg::EDGE_BITS-1:0]  e_addr;
    logic [lese_pkg::EWORD_BITS-1:0] e_wdata, e_rdata;

    function automatic logic [CB-1:0] ring_dist(
        input logic [NB-1:0] x,
        input logic [NB-1:0] y,
        input logic [CB-1:0] n
    );
        logic [CB-1:0] diff;
        logic [CB-1:0] alt;
        diff = (x > y) ? CB'(x - y) : CB'(y - x);
        alt  = (n > diff) ? n - diff : '0;
        return (diff < alt) ? diff : alt;
    endfunction

    // move sources/destinations, in model order
    always_comb begin
        case (cmd.move)
            2'd0: begin
                src_addr = {a_reg, b_reg};
                dst_addr = {a_reg, d_reg};
            end
            2'd1: begin
                src_addr = {b_reg, a_reg};
                dst_addr = {d_reg, a_reg};
            end
            2'd2: begin
                src_addr = {c_reg, d_reg};
                dst_addr = {c_reg, b_reg};
            end
            default: begin
                src_addr = {d_reg, c_reg};
                dst_addr = {b_reg, c_reg};
            end
        endcase
    end

    always_comb begin
        case (cmd.w_asel)
            lese_pkg::WA_IN:  w_addr = {row_reg, col_reg};
            lese_pkg::WA_AD:  w_addr = {a_reg, d_reg};
            lese_pkg::WA_CB:  w_addr = {c_reg, b_reg};
            lese_pkg::WA_SRC: w_addr = src_addr;
            lese_pkg::WA_DST: w_addr = dst_addr;
            default:          w_addr = clr_reg;
        endcase
        case (cmd.w_dsel)
            lese_pkg::WD_IN: w_wdata = weight_reg;
            lese_pkg::WD_RD: w_wdata = w_rdata;
            default:         w_wdata = '0;
        endcase
        e_addr = (cmd.e_asel == lese_pkg::EA_E1) ? e1_reg : e2_reg;
        // edge word: first end low, second end high
        case (cmd.e_dsel)
            lese_pkg::ED_IN: e_wdata = {col_reg, row_reg};
            lese_pkg::ED_CD: e_wdata = {d_reg, c_reg};
            lese_pkg::ED_AD: e_wdata = {d_reg, a_reg};
            default:         e_wdata = {b_reg, c_reg};
        endcase
    end

    lese_ram #(.WIDTH(WB), .DEPTH(lese_pkg::CELLS)) u_weight_ram (
        .aclk  (aclk),
        .we    (cmd.w_we),
        .addr  (w_addr),
        .wdata (w_wdata),
        .rdata (w_rdata)
    );

    lese_ram #(.WIDTH(lese_pkg::EWORD_BITS), .DEPTH(lese_pkg::EDGES)) u_edge_ram (
        .aclk  (aclk),
        .we    (cmd.e_we),
        .addr  (e_addr),
        .wdata (e_wdata),
        .rdata (e_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncnt_reg <= lese_pkg::NCNT_RESET;
            clr_reg  <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_data < lese_pkg::NCNT_MIN) begin
                    ncnt_reg <= lese_pkg::NCNT_MIN;
                end else if (cfg_data > lese_pkg::NCNT_MAX) begin
                    ncnt_reg <= lese_pkg::NCNT_MAX;
                end else begin
                    ncnt_reg <= cfg_data;
                end
            end
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            command_reg    <= in_command;
            row_reg        <= in_row;
            col_reg        <= in_col;
            weight_reg     <= in_weight;
            e1_reg         <= in_e1;
            e2_reg         <= in_e2;
            flip_reg       <= in_flip;
            res_status_reg <= lese_pkg::STAT_OK;
            res_weight_reg <= '0;
            res_first_reg  <= '0;
            res_second_reg <= '0;
        end
        if (cmd.lat_ab) begin
            a_reg <= e_rdata[NB-1:0];
            b_reg <= e_rdata[2*NB-1:NB];
        end
        if (cmd.lat_cd) begin
            c_reg <= flip_reg ? e_rdata[2*NB-1:NB] : e_rdata[NB-1:0];
            d_reg <= flip_reg ? e_rdata[NB-1:0] : e_rdata[2*NB-1:NB];
        end
        if (cmd.link_first) begin
            link_reg <= |w_rdata;
        end else if (cmd.link_next) begin
            link_reg <= link_reg | (|w_rdata);
        end
        if (cmd.dist_cap) begin
            sum_keep_reg <= SB'(ring_dist(a_reg, b_reg, ncnt_reg))
                          + SB'(ring_dist(c_reg, d_reg, ncnt_reg));
            sum_new_reg  <= SB'(ring_dist(a_reg, d_reg, ncnt_reg))
                          + SB'(ring_dist(c_reg, b_reg, ncnt_reg));
        end
        if (cmd.set_status) begin
            res_status_reg <= cmd.status;
        end
        if (cmd.cap_rw) begin
            res_weight_reg <= w_rdata;
        end
        if (cmd.cap_edge) begin
            res_first_reg  <= e_rdata[NB-1:0];
            res_second_reg <= e_rdata[2*NB-1:NB];
        end
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_weight_reg <= res_weight_reg;
            out_first_reg  <= res_first_reg;
            out_second_reg <= res_second_reg;
        end
    end

    assign stat.command   = command_reg;
    assign stat.same_edge = (e1_reg == e2_reg);
    assign stat.shared    = (a_reg == c_reg) || (a_reg == d_reg)
                         || (b_reg == c_reg) || (b_reg == d_reg);
    assign stat.link      = link_reg;
    assign stat.dist_fail = (sum_keep_reg < sum_new_reg);
    assign stat.clr_done  = &clr_reg;

    assign out_status = out_status_reg;
    assign out_weight = out_weight_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;

endmodule

FILE: rtl/core/lese_ctrl.sv
// ----------------------------------------------------------------------------
// lese_ctrl
// Sequencer: clear sweep, command decode, swap steps, result handoff.
// ----------------------------------------------------------------------------
module lese_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  lese_pkg::dp_stat_t  stat,
    output lese_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [16:0] {
        ST_CLEAR  = 17'h00001,
        ST_IDLE   = 17'h00002,
        ST_DECODE = 17'h00004,
        ST_WRD    = 17'h00008,
        ST_ERD    = 17'h00010,
        ST_E1RD   = 17'h00020,
        ST_E2RD   = 17'h00040,
        ST_CHECK  = 17'h00080,
        ST_L1     = 17'h00100,
        ST_L2     = 17'h00200,
        ST_DIST   = 17'h00400,
        ST_MRD    = 17'h00800,
        ST_MWR    = 17'h01000,
        ST_MZR    = 17'h02000,
        ST_EW1    = 17'h04000,
        ST_EW2    = 17'h08000,
        ST_DONE   = 17'h10000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] move_reg, move_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        move_next      = move_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.move       = move_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                cmd.w_we     = 1'b1;
                cmd.w_asel   = lese_pkg::WA_CLR;
                cmd.w_dsel   = lese_pkg::WD_ZERO;
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.cap_in = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.command)
                    lese_pkg::CMD_WR_WEIGHT: begin
                        cmd.w_we   = 1'b1;
                        cmd.w_asel = lese_pkg::WA_IN;
                        cmd.w_dsel = lese_pkg::WD_IN;
                        state_next = ST_DONE;
                    end
                    lese_pkg::CMD_RD_WEIGHT: begin
                        cmd.w_asel = lese_pkg::WA_IN;
                        state_next = ST_WRD;
                    end
                    lese_pkg::CMD_WR_EDGE: begin
                        cmd.e_we   = 1'b1;
                        cmd.e_asel = lese_pkg::EA_E1;
                        cmd.e_dsel = lese_pkg::ED_IN;
                        state_next = ST_DONE;
                    end
                    lese_pkg::CMD_RD_EDGE: begin
                        cmd.e_asel = lese_pkg::EA_E1;
                        state_next = ST_ERD;
                    end
                    lese_pkg::CMD_SWAP: begin
                        cmd.e_asel = lese_pkg::EA_E1;
                        if (stat.same_edge) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = lese_pkg::STAT_SAME_EDGE;
                            state_next     = ST_DONE;
                        end else begin
                            state_next = ST_E1RD;
                        end
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_WRD: begin
                cmd.cap_rw = 1'b1;
                state_next = ST_DONE;
            end
            ST_ERD: begin
                cmd.cap_edge = 1'b1;
                state_next   = ST_DONE;
            end
            ST_E1RD: begin
                cmd.lat_ab = 1'b1;
                cmd.e_asel = lese_pkg::EA_E2;
                state_next = ST_E2RD;
            end
            ST_E2RD: begin
                cmd.lat_cd = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.shared) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = lese_pkg::STAT_SHARED;
                    state_next     = ST_DONE;
                end else begin
                    // c/d are already oriented; rewriting unflipped is harmless
                    cmd.e_we   = 1'b1;
                    cmd.e_asel = lese_pkg::EA_E2;
                    cmd.e_dsel = lese_pkg::ED_CD;
                    cmd.w_asel = lese_pkg::WA_AD;
                    state_next = ST_L1;
                end
            end
            ST_L1: begin
                cmd.link_first = 1'b1;
                cmd.dist_cap   = 1'b1;
                cmd.w_asel     = lese_pkg::WA_CB;
                state_next     = ST_L2;
            end
            ST_L2: begin
                cmd.link_next = 1'b1;
                state_next    = ST_DIST;
            end
            ST_DIST: begin
                move_next = 2'd0;
                if (stat.link) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = lese_pkg::STAT_LINK;
                    state_next     = ST_DONE;
                end else if (stat.dist_fail) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = lese_pkg::STAT_DIST;
                    state_next     = ST_DONE;
                end else begin
                    state_next = ST_MRD;
                end
            end
            ST_MRD: begin
                cmd.w_asel = lese_pkg::WA_SRC;
                state_next = ST_MWR;
            end
            ST_MWR: begin
                cmd.w_we   = 1'b1;
                cmd.w_asel = lese_pkg::WA_DST;
                cmd.w_dsel = lese_pkg::WD_RD;
                state_next = ST_MZR;
            end
            ST_MZR: begin
                cmd.w_we   = 1'b1;
                cmd.w_asel = lese_pkg::WA_SRC;
                cmd.w_dsel = lese_pkg::WD_ZERO;
                move_next  = move_reg + 2'd1;
                state_next = (move_reg == 2'd3) ? ST_EW1 : ST_MRD;
            end
            ST_EW1: begin
                cmd.e_we   = 1'b1;
                cmd.e_asel = lese_pkg::EA_E1;
                cmd.e_dsel = lese_pkg::ED_AD;
                state_next = ST_EW2;
            end
            ST_EW2: begin
                cmd.e_we   = 1'b1;
                cmd.e_asel = lese_pkg::EA_E2;
                cmd.e_dsel = lese_pkg::ED_CB;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            move_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            move_reg      <= move_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted transaction not decoded");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_valid_reg && !out_ready) |=> (state_reg == ST_DONE))
        else $error("result overwritten while output stalled");

    a_last_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MZR && move_reg == 2'd3) |=> (state_reg == ST_EW1))
        else $error("swap did not finish after fourth move");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!in_ready && !out_valid_reg))
        else $error("traffic during clear sweep");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lattice edge swap engine core: host commands
// (weight and edge access, swap attempts) go in on s_, each result on m_ is
// checked against an in-bench model of the weight matrix and edge list.
// ----------------------------------------------------------------------------
module tb_top;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [2:0]  s_tuser = '0;
    logic [55:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [2:0]  m_tuser;
    logic [31:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [6:0]  cfg_data = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] rweight;
        logic [5:0]  rfirst;
        logic [5:0]  rsecond;
    } result_t;

    // model state
    logic [15:0] weights [lese_pkg::CELLS];
    logic [5:0]  end_a [lese_pkg::EDGES];
    logic [5:0]  end_b [lese_pkg::EDGES];
    bit          edge_written [lese_pkg::EDGES];
    int unsigned ring_size;

    result_t pending_results [$];
    int      error_count = 0;
    bit      stall_enable = 1'b1;
    int      stall_cnt = 0;

    lattice_edge_swap_engine_core i_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned ring_dist(int unsigned x, int unsigned y);
        int unsigned diff;
        int unsigned alt;
        diff = x > y ? x - y : y - x;
        alt = ring_size > diff ? ring_size - diff : 0;
        return diff < alt ? diff : alt;
    endfunction

    function automatic int unsigned cidx(logic [5:0] r, logic [5:0] c);
        return int'({r, c});
    endfunction

    function automatic void move_w(logic [5:0] dr, logic [5:0] dc, logic [5:0] sr,
                                   logic [5:0] sc);
        weights[cidx(dr, dc)] = weights[cidx(sr, sc)];
        weights[cidx(sr, sc)] = '0;
    endfunction

    // Apply one command to the model, return its result.
    function automatic result_t predict_command(logic [2:0] cmd, logic [5:0] row,
            logic [5:0] col, logic [15:0] wv, logic [9:0] e1, logic [9:0] e2,
            logic flip);
        result_t r;
        logic [5:0] a, b, c, d, t;
        r = '0;
        case (cmd)
            lese_pkg::CMD_WR_WEIGHT: weights[cidx(row, col)] = wv;
            lese_pkg::CMD_RD_WEIGHT: r.rweight = weights[cidx(row, col)];
            lese_pkg::CMD_WR_EDGE: begin
                end_a[e1] = row;
                end_b[e1] = col;
                edge_written[e1] = 1'b1;
            end
            lese_pkg::CMD_RD_EDGE: begin
                r.rfirst = end_a[e1];
                r.rsecond = end_b[e1];
            end
            lese_pkg::CMD_SWAP: begin
                if (e1 == e2) begin
                    r.status = lese_pkg::STAT_SAME_EDGE;
                end else begin
                    a = end_a[e1]; b = end_b[e1]; c = end_a[e2]; d = end_b[e2];
                    if (a == c || a == d || b == c || b == d) begin
                        r.status = lese_pkg::STAT_SHARED;
                    end else begin
                        if (flip) begin
                            t = c; c = d; d = t;
                            end_a[e2] = c;
                            end_b[e2] = d;
                        end
                        if (weights[cidx(a, d)] != 0 || weights[cidx(c, b)] != 0) begin
                            r.status = lese_pkg::STAT_LINK;
                        end else if (ring_dist(a, b) + ring_dist(c, d) <
                                     ring_dist(a, d) + ring_dist(c, b)) begin
                            r.status = lese_pkg::STAT_DIST;
                        end else begin
                            move_w(a, d, a, b);
                            move_w(d, a, b, a);
                            move_w(c, b, c, d);
                            move_w(b, c, d, c);
                            end_b[e1] = d;
                            end_b[e2] = b;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // idle burst on the input side; tvalid drops only when a gap is taken
    task automatic random_gap();
        if (stall_enable && $urandom_range(3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge aclk);
        end
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
    endtask

    // Send one command transaction and record its expected result.
    task automatic send_command(logic [2:0] cmd, logic [5:0] row, logic [5:0] col,
            logic [15:0] wv, logic [9:0] e1, logic [9:0] e2, logic flip);
        random_gap();
        s_tuser <= cmd;
        s_tdata <= {7'd0, flip, e2, e1, wv, col, row};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_command(cmd, row, col, wv, e1, e2, flip));
    endtask

    // Node count written only while idle; settle time covers a full swap.
    task automatic set_ring_size(logic [6:0] value);
        idle_input();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        ring_size = value < 2 ? 2 : (value > 64 ? 64 : value);
    endtask

    // result checker and random receiver stalls
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tuser, -1);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser != want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[15:0] != want.rweight)
                        report_mismatch("read_weight", m_tdata[15:0], want.rweight);
                    if (m_tdata[21:16] != want.rfirst)
                        report_mismatch("read_first_node", m_tdata[21:16], want.rfirst);
                    if (m_tdata[27:22] != want.rsecond)
                        report_mismatch("read_second_node", m_tdata[27:22], want.rsecond);
                    if (m_tdata[31:28] != 0)
                        report_mismatch("pad", m_tdata[31:28], 0);
                end
            end
            if (stall_enable && stall_cnt != 0) begin
                m_tready <= 1'b0;
                stall_cnt = stall_cnt - 1;
            end else if (stall_enable && $urandom_range(3) == 0) begin
                m_tready <= 1'b0;
                stall_cnt = int'($urandom_range(4, 0));
            end else begin
                m_tready <= 1'b1;
                stall_cnt = 0;
            end
        end
    end

    function automatic logic [9:0] some_written_edge(int unsigned span);
        logic [9:0] e;
        e = 10'($urandom_range(span - 1));
        while (!edge_written[e]) e = 10'($urandom_range(span - 1));
        return e;
    endfunction

    // Extremes of fields, every command, unused codes.
    task automatic test_directed();
        send_command(lese_pkg::CMD_WR_WEIGHT, 6'd63, 6'd0, 16'hFFFF, 10'd0, 10'd0, 1'b0);
        send_command(lese_pkg::CMD_RD_WEIGHT, 6'd63, 6'd0, 16'h0, 10'h3FF, 10'h3FF, 1'b1);
        send_command(lese_pkg::CMD_RD_WEIGHT, 6'd0, 6'd63, 16'h0, 10'd0, 10'd0, 1'b0);
        send_command(lese_pkg::CMD_WR_EDGE, 6'd63, 6'd62, 16'hFFFF, 10'h3FF, 10'd0, 1'b1);
        send_command(lese_pkg::CMD_RD_EDGE, 6'd0, 6'd0, 16'h0, 10'h3FF, 10'h3FF, 1'b0);
        send_command(lese_pkg::CMD_WR_EDGE, 6'd0, 6'd1, 16'h0, 10'd0, 10'd0, 1'b0);
        send_command(lese_pkg::CMD_WR_EDGE, 6'd5, 6'd5, 16'h0, 10'd1, 10'd0, 1'b0);
        send_command(lese_pkg::CMD_WR_EDGE, 6'd2, 6'd3, 16'h0, 10'd2, 10'd0, 1'b0);
        send_command(3'd5, 6'd63, 6'd63, 16'hFFFF, 10'h3FF, 10'h3FF, 1'b1);
        send_command(3'd6, 6'd1, 6'd2, 16'h1, 10'd0, 10'd0, 1'b0);
        send_command(3'd7, 6'd1, 6'd2, 16'h1, 10'd0, 10'd0, 1'b0);
        // same edge, distance reject, self loop swap, flip, link exists
        send_command(lese_pkg::CMD_SWAP, 6'd0, 6'd0, 16'h0, 10'd0, 10'd0, 1'b0);
        send_command(lese_pkg::CMD_SWAP, 6'd0, 6'd0, 16'h0, 10'd0, 10'h3FF, 1'b1);
        send_command(lese_pkg::CMD_SWAP, 6'd0, 6'd0, 16'h0, 10'd1, 10'd2, 1'b1);
        send_command(lese_pkg::CMD_RD_EDGE, 6'd0, 6'd0, 16'h0, 10'd2, 10'd0, 1'b0);
        send_command(lese_pkg::CMD_WR_WEIGHT, 6'd0, 6'd3, 16'h7, 10'd0, 10'd0, 1'b0);
        send_command(lese_pkg::CMD_SWAP, 6'd0, 6'd0, 16'h0, 10'd0, 10'd2, 1'b0);
        send_command(lese_pkg::CMD_SWAP, 6'd0, 6'd0, 16'h0, 10'd0, 10'd2, 1'b1);
        send_command(lese_pkg::CMD_RD_EDGE, 6'd0, 6'd0, 16'h0, 10'd2, 10'd0, 1'b0);
    endtask

    // Random phase: small graph region so swaps hit all outcomes.
    task automatic test_random_swaps(int count, int unsigned nodes, int unsigned span);
        logic [5:0] r, c;
        logic [15:0] w;
        logic [9:0] e1, e2;
        int unsigned pick;
        for (int i = 0; i < span; i++) begin
            r = 6'($urandom_range(nodes - 1));
            c = 6'($urandom_range(nodes - 1));
            send_command(lese_pkg::CMD_WR_EDGE, r, c, 16'h0, 10'(i), 10'd0, 1'b0);
            w = 16'($urandom_range(16'hFFFF, 1));
            send_command(lese_pkg::CMD_WR_WEIGHT, r, c, w, 10'd0, 10'd0, 1'b0);
            send_command(lese_pkg::CMD_WR_WEIGHT, c, r, w, 10'd0, 10'd0, 1'b0);
        end
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            r = 6'($urandom_range(nodes - 1));
            c = 6'($urandom_range(nodes - 1));
            if (pick < 5) begin
                r = 6'($urandom); c = 6'($urandom);
            end
            w = $urandom_range(1) ? 16'h0 : 16'($urandom);
            e1 = some_written_edge(span);
            e2 = $urandom_range(9) == 0 ? e1 : some_written_edge(span);
            if (pick < 50)
                send_command(lese_pkg::CMD_SWAP, r, c, w, e1, e2, 1'($urandom));
            else if (pick < 62)
                send_command(lese_pkg::CMD_WR_WEIGHT, r, c, w, e1, e2, 1'($urandom));
            else if (pick < 77)
                send_command(lese_pkg::CMD_RD_WEIGHT, r, c, w, 10'($urandom), e2,
                             1'($urandom));
            else if (pick < 85)
                send_command(lese_pkg::CMD_WR_EDGE, r, c, w, e1, 10'($urandom),
                             1'($urandom));
            else if (pick < 95)
                send_command(lese_pkg::CMD_RD_EDGE, r, c, w, e1, 10'($urandom),
                             1'($urandom));
            else
                send_command(3'($urandom_range(7, 5)), r, c, w, 10'($urandom),
                             10'($urandom), 1'($urandom));
        end
    endtask

    // Edges up high in the index and node range.
    task automatic test_high_indices();
        for (int i = 0; i < 20; i++)
            send_command(lese_pkg::CMD_WR_EDGE, 6'($urandom_range(63, 32)), 6'($urandom),
                         16'h0, 10'(1023 - i), 10'd0, 1'b0);
        for (int i = 0; i < 40; i++)
            send_command(lese_pkg::CMD_SWAP, 6'd0, 6'd0, 16'h0,
                         10'(1023 - $urandom_range(19)),
                         10'(1023 - $urandom_range(19)), 1'($urandom));
        for (int i = 0; i < 20; i++)
            send_command(lese_pkg::CMD_RD_EDGE, 6'd0, 6'd0, 16'h0, 10'(1023 - i), 10'd0,
                         1'b0);
    endtask

    initial begin
        ring_size = 64;
        for (int i = 0; i < lese_pkg::CELLS; i++) weights[i] = '0;
        for (int i = 0; i < lese_pkg::EDGES; i++) begin
            end_a[i] = '0; end_b[i] = '0; edge_written[i] = 1'b0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        set_ring_size(7'd2);
        test_random_swaps(250, 8, 12);
        set_ring_size(7'd0);
        test_random_swaps(150, 16, 20);
        set_ring_size(7'd127);
        test_high_indices();
        test_random_swaps(250, 64, 40);
        set_ring_size(7'd64);
        test_random_swaps(120, 32, 30);
        set_ring_size(7'd13);
        test_random_swaps(50, 20, 16);
        stall_enable = 1'b0;
        test_random_swaps(150, 12, 10);
        idle_input();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (error_count == 0)
            $display("lattice_edge_swap_engine_core regression: pass");
        else
            $display("lattice_edge_swap_engine_core regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("lattice_edge_swap_engine_core regression: fail");
        $finish;
    end
endmodule
